// ----- src/lbh_pkg.sv -----
`timescale 1ns / 1ps

package lbh_pkg;

    localparam int NUM_BUCKETS = 166;
    localparam int BUCKET_W    = $clog2(NUM_BUCKETS);

    // operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [63:0] MIN_RESTART = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_UPDATE
    } lbh_state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] sample;
        logic [7:0]  bucket_index;
    } lbh_in_t;

    typedef struct packed {
        logic [7:0]  sample_bucket;
        logic [63:0] bucket_count;
        logic [63:0] min_seen;
        logic [63:0] max_seen;
        logic [63:0] sample_sum;
        logic [63:0] sample_count;
    } lbh_out_t;

    typedef struct packed {
        logic                rd_en;
        logic [BUCKET_W-1:0] rd_addr;
        logic                wr_en;
        logic [BUCKET_W-1:0] wr_addr;
        logic                clear;
    } lbh_mem_req_t;

    // lower threshold of each bucket, ascending
    localparam logic [63:0] THRESHOLDS [NUM_BUCKETS] = '{
        64'd0,
        64'd1, 64'd2, 64'd3, 64'd4, 64'd5,
        64'd6, 64'd7, 64'd8, 64'd9, 64'd10,
        64'd12, 64'd14, 64'd16, 64'd18, 64'd20,
        64'd25, 64'd30, 64'd35, 64'd40, 64'd45, 64'd50,
        64'd60, 64'd70, 64'd80, 64'd90, 64'd100,
        64'd120, 64'd140, 64'd160, 64'd180, 64'd200,
        64'd250, 64'd300, 64'd350, 64'd400, 64'd450, 64'd500,
        64'd600, 64'd700, 64'd800, 64'd900, 64'd1000,
        64'd1200, 64'd1400, 64'd1600, 64'd1800, 64'd2000,
        64'd2500, 64'd3000, 64'd3500, 64'd4000, 64'd4500, 64'd5000,
        64'd6000, 64'd7000, 64'd8000, 64'd9000, 64'd10000,
        64'd12000, 64'd14000, 64'd16000, 64'd18000, 64'd20000,
        64'd25000, 64'd30000, 64'd35000, 64'd40000, 64'd45000, 64'd50000,
        64'd60000, 64'd70000, 64'd80000, 64'd90000, 64'd100000,
        64'd120000, 64'd140000, 64'd160000, 64'd180000, 64'd200000,
        64'd250000, 64'd300000, 64'd350000, 64'd400000, 64'd450000, 64'd500000,
        64'd600000, 64'd700000, 64'd800000, 64'd900000, 64'd1000000,
        64'd1200000, 64'd1400000, 64'd1600000, 64'd1800000, 64'd2000000,
        64'd2500000, 64'd3000000, 64'd3500000, 64'd4000000, 64'd4500000,
        64'd5000000,
        64'd6000000, 64'd7000000, 64'd8000000, 64'd9000000, 64'd10000000,
        64'd12000000, 64'd14000000, 64'd16000000, 64'd18000000, 64'd20000000,
        64'd25000000, 64'd30000000, 64'd35000000, 64'd40000000, 64'd45000000,
        64'd50000000,
        64'd60000000, 64'd70000000, 64'd80000000, 64'd90000000, 64'd100000000,
        64'd120000000, 64'd140000000, 64'd160000000, 64'd180000000,
        64'd200000000,
        64'd250000000, 64'd300000000, 64'd350000000, 64'd400000000,
        64'd450000000, 64'd500000000,
        64'd600000000, 64'd700000000, 64'd800000000, 64'd900000000,
        64'd1000000000,
        64'd1200000000, 64'd1400000000, 64'd1600000000, 64'd1800000000,
        64'd2000000000,
        64'd2500000000, 64'd3000000000, 64'd3500000000, 64'd4000000000,
        64'd4500000000, 64'd5000000000,
        64'd6000000000, 64'd7000000000, 64'd8000000000, 64'd9000000000,
        64'd10000000000,
        64'd12000000000, 64'd14000000000, 64'd16000000000, 64'd18000000000,
        64'd20000000000,
        64'd25000000000, 64'd30000000000, 64'd35000000000, 64'd40000000000,
        64'd45000000000, 64'd50000000000
    };

endpackage

// ----- src/lbh_stream_if.sv -----
`timescale 1ns / 1ps

interface lbh_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/lbh_bucket_find.sv -----
`timescale 1ns / 1ps

module lbh_bucket_find import lbh_pkg::*;
(
    input  logic                clk,
    input  logic                load,
    input  logic [63:0]         sample,
    output logic [BUCKET_W-1:0] bucket
);

    // thermometer of threshold compares, taken at the accept edge
    logic [NUM_BUCKETS-1:0] therm_reg;
    logic [NUM_BUCKETS-1:0] therm_next;
    logic [BUCKET_W-1:0]    idx;
    logic [BUCKET_W-1:0]    cand;

    always_comb
    begin
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            therm_next[i] = (sample >= THRESHOLDS[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            therm_reg <= therm_next;
        end
    end

    // last set bit of the thermometer, one index bit per step
    always_comb
    begin
        idx  = '0;
        cand = '0;
        for (int b = BUCKET_W - 1; b >= 0; b--)
        begin
            cand = idx | (BUCKET_W'(1) << b);
            if ((cand < BUCKET_W'(NUM_BUCKETS)) && therm_reg[cand])
            begin
                idx = cand;
            end
        end
        bucket = idx;
    end

endmodule

// ----- src/lbh_count_mem.sv -----
`timescale 1ns / 1ps

module lbh_count_mem import lbh_pkg::*;
#(
    parameter int COUNT_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lbh_mem_req_t           req,
    input  logic [COUNT_WIDTH-1:0] wr_data,
    output logic [COUNT_WIDTH-1:0] rd_count
);

    logic [COUNT_WIDTH-1:0] mem [NUM_BUCKETS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_hit_reg;
    logic [NUM_BUCKETS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
            rd_hit_reg  <= valid_reg[req.rd_addr];
        end
    end

    // entries never written since reset or clear read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_count = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ----- src/log_bucket_histogram.sv -----
// log bucket histogram: 64-bit samples sorted into 166 decade buckets
// result: beat registered at the end of the update state, once the output register is free
// one item at a time: a new sample is taken as the last result is handed on, set by the bucket
//   count read-modify-write (count memory read in the find state, written back in the update state)
// reset: statistics restart (min all ones), bucket valid bits cleared so
//   every bucket reads zero at once; no clearing pass
`timescale 1ns / 1ps

module log_bucket_histogram import lbh_pkg::*;
#(
    parameter int COUNT_WIDTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    lbh_stream_if.sink    samples,
    lbh_stream_if.source  results
);

    lbh_state_t state_reg;
    lbh_state_t state_next;

    logic in_beat;
    logic out_free;
    logic load;
    logic capture;
    logic finish;

    // item registers
    logic [1:0]          op_reg;
    logic [63:0]         sample_reg;
    logic [7:0]          index_reg;
    logic [BUCKET_W-1:0] addr_reg;
    logic                hit_reg;

    logic [BUCKET_W-1:0] find_bucket;
    logic [BUCKET_W-1:0] find_addr;
    logic                find_in_range;

    // count memory
    lbh_mem_req_t           mem_req;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic [COUNT_WIDTH-1:0] new_count;

    // running statistics
    logic [63:0]            min_reg, min_next;
    logic [63:0]            max_reg, max_next;
    logic [63:0]            sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;

    // output stage
    logic     out_valid_reg;
    lbh_out_t out_data_reg;
    lbh_out_t out_data_next;

    assign in_beat  = samples.valid & samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    // threshold compare and bucket encode
    lbh_bucket_find u_find
    (
        .clk    (clk),
        .load   (load),
        .sample (samples.data.sample),
        .bucket (find_bucket)
    );

    lbh_count_mem #(.COUNT_WIDTH(COUNT_WIDTH)) u_mem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .wr_data  (new_count),
        .rd_count (rd_count)
    );

    // address for the read: chosen bucket on add, requested one on read
    always_comb
    begin
        find_in_range = (op_reg == OP_ADD) ||
                        ((op_reg == OP_READ) && (index_reg < 8'(NUM_BUCKETS)));
        find_addr     = (op_reg == OP_ADD) ? find_bucket : index_reg[BUCKET_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // a new beat is taken in the same cycle the result leaves
                if (out_free)
                begin
                    state_next = samples.valid ? ST_FIND : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        samples.ready = 1'b0;
        capture       = 1'b0;
        finish        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
            end
            ST_FIND:
            begin
                capture = 1'b1;
            end
            ST_UPDATE:
            begin
                samples.ready = out_free;
                finish        = out_free;
            end
            default:
            begin
                samples.ready = 1'b0;
            end
        endcase
    end

    assign load = in_beat;

    // memory requests; writes and clears only when the result is handed on
    always_comb
    begin
        mem_req.rd_en   = capture && find_in_range;
        mem_req.rd_addr = find_in_range ? find_addr : '0;
        mem_req.wr_en   = finish && (op_reg == OP_ADD);
        mem_req.wr_addr = addr_reg;
        mem_req.clear   = finish && (op_reg == OP_CLEAR);
    end

    assign new_count = rd_count + COUNT_WIDTH'(1);

    // statistics update and result assembly
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        out_data_next.sample_bucket = '0;
        out_data_next.bucket_count  = '0;
        case (op_reg)
            OP_ADD:
            begin
                min_next = (sample_reg < min_reg) ? sample_reg : min_reg;
                max_next = (sample_reg > max_reg) ? sample_reg : max_reg;
                sum_next = sum_reg + sample_reg;
                cnt_next = cnt_reg + COUNT_WIDTH'(1);
                out_data_next.sample_bucket = 8'(addr_reg);
                out_data_next.bucket_count  = 64'(new_count);
            end
            OP_READ:
            begin
                // out of range index reads as zero
                out_data_next.bucket_count = hit_reg ? 64'(rd_count) : '0;
            end
            OP_CLEAR:
            begin
                min_next = MIN_RESTART;
                max_next = '0;
                sum_next = '0;
                cnt_next = '0;
            end
            default:
            begin
                // unused code: current statistics only
                out_data_next.bucket_count = '0;
            end
        endcase
        out_data_next.min_seen     = min_next;
        out_data_next.max_seen     = max_next;
        out_data_next.sample_sum   = sum_next;
        out_data_next.sample_count = 64'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            min_reg       <= MIN_RESTART;
            max_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                min_reg       <= min_next;
                max_reg       <= max_next;
                sum_reg       <= sum_next;
                cnt_reg       <= cnt_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg     <= samples.data.operation;
            sample_reg <= samples.data.sample;
            index_reg  <= samples.data.bucket_index;
        end
        if (capture)
        begin
            addr_reg <= find_addr;
            hit_reg  <= find_in_range;
        end
        if (finish)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

endmodule

// ----- src/lbh_checker.sv -----
`timescale 1ns / 1ps

module lbh_checker import lbh_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input lbh_out_t out_data
);

    // output beat holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");

    // one item at a time: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // chosen bucket is a real bucket
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.sample_bucket < 8'(NUM_BUCKETS))
        else $error("bucket index out of range");

    // min and max are either empty markers or ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.min_seen <= out_data.max_seen) ||
                      ((out_data.min_seen == MIN_RESTART) && (out_data.max_seen == '0)))
        else $error("min and max statistics inconsistent");

endmodule

bind log_bucket_histogram lbh_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import lbh_pkg::*;

    // operation code the block leaves unused, it must change nothing
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         MAX_SHOWN   = 10;

    logic clk = 1'b0;
    logic rst_n;

    always #4 clk = ~clk;

    lbh_stream_if #(.payload_t(lbh_in_t))  sample_ch ();
    lbh_stream_if #(.payload_t(lbh_out_t)) result_ch ();

    log_bucket_histogram #(
        .COUNT_WIDTH(64)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(sample_ch),
        .results(result_ch)
    );

    // ------------------------------------------------------------------
    // histogram shadow: bucket counters plus running statistics
    // ------------------------------------------------------------------
    logic [63:0] bound_tbl   [NUM_BUCKETS];
    logic [63:0] hist_counts [NUM_BUCKETS];
    logic [63:0] stat_min;
    logic [63:0] stat_max;
    logic [63:0] stat_sum;
    logic [63:0] stat_count;

    // results still owed by the block, oldest first
    lbh_out_t    owed_results [$];
    lbh_out_t    owed_head;
    int          mismatch_count = 0;

    // idle and stall control
    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    bit          hold_req     = 1'b0;
    bit          hold_active  = 1'b0;
    int          stall_left   = 0;

    // lower bounds: 0, 1..5, then per decade 6..10, 12..20 step 2, 25..50 step 5
    function automatic void build_bounds();
        logic [63:0] scale;
        int          n;
        for (int i = 0; i <= 5; i++)
            bound_tbl[i] = 64'(i);
        n     = 6;
        scale = 64'd1;
        repeat (10)
        begin
            for (int m = 6; m <= 10; m++)
            begin
                bound_tbl[n] = 64'(m) * scale;
                n++;
            end
            for (int m = 12; m <= 20; m += 2)
            begin
                bound_tbl[n] = 64'(m) * scale;
                n++;
            end
            for (int m = 25; m <= 50; m += 5)
            begin
                bound_tbl[n] = 64'(m) * scale;
                n++;
            end
            scale = scale * 64'd10;
        end
    endfunction

    // empty histogram, min restarts at all ones
    function automatic void clear_stats();
        foreach (hist_counts[i])
            hist_counts[i] = '0;
        stat_min   = '1;
        stat_max   = '0;
        stat_sum   = '0;
        stat_count = '0;
    endfunction

    // last bucket whose lower bound does not exceed the sample
    function automatic int find_bucket(logic [63:0] v);
        int sel;
        sel = 0;
        for (int i = 0; i < NUM_BUCKETS; i++)
            if (bound_tbl[i] <= v)
                sel = i;
        return sel;
    endfunction

    // apply one beat to the shadow histogram and return the result it owes
    function automatic lbh_out_t histogram_step(lbh_in_t it);
        lbh_out_t r;
        int       b;
        r = '0;
        case (it.operation)
            OP_ADD:
            begin
                if (it.sample > stat_max)
                    stat_max = it.sample;
                if (it.sample < stat_min)
                    stat_min = it.sample;
                stat_sum       = stat_sum + it.sample;
                stat_count     = stat_count + 64'd1;
                b              = find_bucket(it.sample);
                hist_counts[b] = hist_counts[b] + 64'd1;
                r.sample_bucket = 8'(b);
                r.bucket_count  = hist_counts[b];
            end
            OP_READ:
            begin
                // out of range index reads as zero
                if (it.bucket_index < NUM_BUCKETS)
                    r.bucket_count = hist_counts[it.bucket_index];
            end
            OP_CLEAR:
                clear_stats();
            default:
            begin
                // unused code: statistics only
            end
        endcase
        r.min_seen     = stat_min;
        r.max_seen     = stat_max;
        r.sample_sum   = stat_sum;
        r.sample_count = stat_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking, sampled at the rising edge
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, logic [63:0] expv, logic [63:0] actv);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%0t mismatch %s: expected %h actual %h", $realtime, what, expv, actv);
    endtask

    task automatic check_field(string what, logic [63:0] expv, logic [63:0] actv);
        if (expv !== actv)
            note_mismatch(what, expv, actv);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (owed_results.size() == 0)
            begin
                // beat with nothing owed
                note_mismatch("unexpected result beat", '0, result_ch.data.sample_count);
            end
            else
            begin
                owed_head = owed_results.pop_front();
                check_field("sample_bucket", 64'(owed_head.sample_bucket),
                            64'(result_ch.data.sample_bucket));
                check_field("bucket_count", owed_head.bucket_count,
                            result_ch.data.bucket_count);
                check_field("min_seen", owed_head.min_seen, result_ch.data.min_seen);
                check_field("max_seen", owed_head.max_seen, result_ch.data.max_seen);
                check_field("sample_sum", owed_head.sample_sum, result_ch.data.sample_sum);
                check_field("sample_count", owed_head.sample_count,
                            result_ch.data.sample_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // result side ready: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n !== 1'b1)
            result_ch.ready <= 1'b0;
        else if (hold_active)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (sink_idle_en && $urandom_range(0, 6) == 0)
        begin
            // stall burst starting with this cycle, of random length
            result_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 17);
        end
        else
            result_ch.ready <= 1'b1;
    end

    // long hold-off counted on rising edges so it never races the ready driver
    always
    begin
        wait (hold_req);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        hold_req    = 1'b0;
    end

    // ------------------------------------------------------------------
    // sample side: one beat per call, entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] op, input logic [63:0] v,
                             input logic [7:0] idx);
        lbh_in_t it;
        int      gap;
        it.operation    = op;
        it.sample       = v;
        it.bucket_index = idx;
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= it;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        owed_results.insert(owed_results.size(), histogram_step(it));
        @(negedge clk);
    endtask

    // drop valid, then let every owed result come back
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // samples skewed toward bucket edges, small values and the far top
    function automatic logic [63:0] pick_sample();
        logic [63:0] v;
        int          k;
        case ($urandom_range(0, 4))
            0:
            begin
                k = $urandom_range(0, NUM_BUCKETS - 1);
                v = bound_tbl[k] + 64'($urandom_range(0, 2)) - 64'd1;
            end
            1:       v = 64'($urandom_range(0, 1000));
            2:       v = {$urandom, $urandom};
            3:       v = {28'd0, 4'($urandom_range(0, 15)), $urandom};
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, NUM_BUCKETS - 1));
    endfunction

    // one random beat: mostly adds, reads often, clears rare
    task automatic send_random_beat();
        int          r;
        logic [1:0]  op;
        r = $urandom_range(0, 99);
        if (r < 70)
            op = OP_ADD;
        else if (r < 92)
            op = OP_READ;
        else if (r < 97)
            op = OP_UNUSED;
        else
            op = OP_CLEAR;
        send_beat(op, pick_sample(), pick_index());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, bucket edges, every operation and the corner cases
    task automatic test_directed();
        send_beat(OP_ADD,   64'd0,            8'd0);
        send_beat(OP_ADD,   64'd1,            8'd0);
        send_beat(OP_ADD,   64'd5,            8'd0);
        send_beat(OP_ADD,   64'd6,            8'd0);
        send_beat(OP_ADD,   64'd11,           8'd0);
        send_beat(OP_ADD,   64'd49999999999,  8'd0);
        send_beat(OP_ADD,   64'd50000000000,  8'd0);
        // top of the range lands in the open last bucket and wraps the sum
        send_beat(OP_ADD,   '1,               8'hff);
        send_beat(OP_ADD,   64'h8000_0000_0000_0000, 8'd0);
        send_beat(OP_READ,  '0,               8'd0);
        send_beat(OP_READ,  '1,               8'd165);
        send_beat(OP_READ,  '0,               8'd166);
        send_beat(OP_READ,  '0,               8'd255);
        send_beat(OP_UNUSED, '1,              8'd165);
        send_beat(OP_CLEAR, '0,               8'd0);
        send_beat(OP_READ,  '0,               8'd165);
        send_beat(OP_UNUSED, '0,              8'd0);
        send_beat(OP_ADD,   64'hffff_ffff_ffff_fffe, 8'd0);
        send_beat(OP_ADD,   64'd7,            8'd0);
        send_beat(OP_ADD,   64'd7,            8'd0);
        send_beat(OP_READ,  '0,               8'd7);
        send_beat(OP_CLEAR, '1,               8'hff);
        drain();
    endtask

    // random mix with idling on both sides
    task automatic test_random_mix();
        repeat (700)
            send_random_beat();
        drain();
    endtask

    // result side held off while the sample side keeps offering beats
    task automatic test_backpressure();
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        repeat (40)
            send_random_beat();
        drain();
        src_idle_en = 1'b1;
    endtask

    // closing stretch at full rate, no idling anywhere
    task automatic test_full_rate();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (300)
            send_random_beat();
        drain();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        result_ch.ready = 1'b0;
        build_bounds();
        clear_stats();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_mix();
        test_backpressure();
        test_full_rate();

        // let the last result beats settle before the verdict
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lbh_pkg.sv
src/lbh_stream_if.sv
src/lbh_bucket_find.sv
src/lbh_count_mem.sv
src/log_bucket_histogram.sv
src/lbh_checker.sv
verif/tb_top.sv
